// File: src/tpcv_pkg.sv
// Shared types, widths and helpers for the three-point circle vote scorer.
// No dependencies; every other source file but tpcv_ram imports this package.
`default_nettype none

package tpcv_pkg;

    // Store geometry and coordinate width.
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 11;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 2 * COORD_BITS;
    localparam int FRAC_BITS  = 4;

    // Configuration port.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MINR_W    = 11;
    localparam int BANDH_W   = 8;
    localparam int MINDET_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HALF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DET    = 2'd2;

    // Arithmetic widths.
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DET_W     = PROD_W + 1;
    localparam int SQ_W      = PROD_W + 1;
    localparam int MP_W      = DIFF_W + SQ_W;
    localparam int NUM_W     = MP_W + 1 + 3;
    localparam int DN_W      = NUM_W + 1;
    localparam int DD_W      = DET_W + 1;
    localparam int OFF_MAG_W = 25;
    localparam int OFF_W     = OFF_MAG_W + 1;
    localparam int CEN_W     = OFF_W + 1;
    localparam int OSQ_W     = 2 * OFF_W;
    localparam int R2_W      = 2 * OFF_MAG_W;
    localparam int ROOT_W    = R2_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int BAND_W    = ROOT_W + 1;
    localparam int HI_W      = 2 * BAND_W;
    localparam int DR_W      = CEN_W + 1;
    localparam int DSQ_W     = 2 * DR_W;
    localparam int D2_W      = DSQ_W + 1;
    localparam int OUT_W     = 24;

    localparam logic [OFF_MAG_W-1:0] OFF_CLAMP = OFF_MAG_W'(1) << (OFF_MAG_W - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SMALL     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // Datapath step commanded by the controller.
    typedef enum logic [4:0] {
        OP_IDLE, OP_ACCEPT, OP_RD_A, OP_RD_B, OP_RD_C, OP_DIFF, OP_PROD, OP_SUM,
        OP_CHK, OP_NUM, OP_NUMS, OP_DIVR, OP_DIVC, OP_CEN, OP_SQ, OP_R2,
        OP_SQRT, OP_RAD, OP_RCHK, OP_BAND, OP_VOTE, OP_WAIT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_DIFF, S_PROD, S_SUM, S_CHK, S_NUM,
        S_NUMS, S_DIVR, S_WDIVR, S_DIVC, S_WDIVC, S_CEN, S_SQ, S_R2, S_SQRT,
        S_WSQRT, S_RAD, S_RCHK, S_BAND, S_VOTE, S_DONE
    } t_state;

    typedef struct packed {
        logic bad_index;
        logic collinear;
        logic small_rad;
        logic div_busy;
        logic sqrt_busy;
        logic vote_done;
    } t_stat;

    // Saturate a signed center value to the output width.
    function automatic logic [OUT_W-1:0] sat_center(input logic signed [CEN_W-1:0] v);
        logic signed [CEN_W-1:0] hi_lim;
        logic signed [CEN_W-1:0] lo_lim;
        hi_lim = CEN_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
        lo_lim = -CEN_W'(64'sd1 <<< (OUT_W - 1));
        if (v > hi_lim) begin
            return hi_lim[OUT_W-1:0];
        end else if (v < lo_lim) begin
            return lo_lim[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/tpcv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tpcv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/tpcv_div.sv
// Bit-serial restoring divider giving round(num/den), ties away from zero,
// with the magnitude clamped. Depends on tpcv_pkg.
`default_nettype none

module tpcv_div
    import tpcv_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic signed [DET_W-1:0] i_den,
    output logic                         o_busy,
    output logic signed [OFF_W-1:0]      o_quot
);

    localparam int CNT_DW = $clog2(DN_W + 1);

    logic [DN_W-1:0]   r_n;
    logic [DN_W-1:0]   r_q;
    logic [DD_W:0]     r_rem;
    logic [DD_W-1:0]   r_d;
    logic [CNT_DW-1:0] r_cnt;
    logic              r_busy;
    logic              r_neg;

    logic [NUM_W-1:0]     an;
    logic [DET_W-1:0]     ad;
    logic [DD_W:0]        rem_sh;
    logic                 ge;
    logic [OFF_MAG_W-1:0] mag;

    always_comb begin
        an     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        ad     = i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
        rem_sh = {r_rem[DD_W-1:0], r_n[DN_W-1]};
        ge     = rem_sh >= {1'b0, r_d};
        mag    = (r_q > DN_W'(OFF_CLAMP)) ? OFF_CLAMP : r_q[OFF_MAG_W-1:0];
        o_quot = r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        o_busy = r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_DW'(DN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_DW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // Dividend 2|n|+|d| over divisor 2|d| rounds half away from zero.
            r_n   <= {an, 1'b0} + DN_W'(ad);
            r_d   <= {ad, 1'b0};
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= i_num[NUM_W-1] ^ i_den[DET_W-1];
        end else if (r_busy) begin
            r_n   <= {r_n[DN_W-2:0], 1'b0};
            r_rem <= ge ? rem_sh - {1'b0, r_d} : rem_sh;
            r_q   <= {r_q[DN_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// File: src/tpcv_ctrl.sv
// Controller state machine for the circle vote scorer: sequences the
// datapath steps of one evaluation. Depends on tpcv_pkg.
`default_nettype none

module tpcv_ctrl
    import tpcv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_req_type,
    input  wire t_stat i_stat,
    output t_op        o_op,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_req_type) begin
                    n_state = i_stat.bad_index ? S_DONE : S_RD_A;
                end
            end
            S_RD_A:  n_state = S_RD_B;
            S_RD_B:  n_state = S_RD_C;
            S_RD_C:  n_state = S_DIFF;
            S_DIFF:  n_state = S_PROD;
            S_PROD:  n_state = S_SUM;
            S_SUM:   n_state = S_CHK;
            S_CHK:   n_state = i_stat.collinear ? S_DONE : S_NUM;
            S_NUM:   n_state = S_NUMS;
            S_NUMS:  n_state = S_DIVR;
            S_DIVR:  n_state = S_WDIVR;
            S_WDIVR: n_state = i_stat.div_busy ? S_WDIVR : S_DIVC;
            S_DIVC:  n_state = S_WDIVC;
            S_WDIVC: n_state = i_stat.div_busy ? S_WDIVC : S_CEN;
            S_CEN:   n_state = S_SQ;
            S_SQ:    n_state = S_R2;
            S_R2:    n_state = S_SQRT;
            S_SQRT:  n_state = S_WSQRT;
            S_WSQRT: n_state = i_stat.sqrt_busy ? S_WSQRT : S_RAD;
            S_RAD:   n_state = S_RCHK;
            S_RCHK:  n_state = i_stat.small_rad ? S_DONE : S_BAND;
            S_BAND:  n_state = S_VOTE;
            S_VOTE:  n_state = i_stat.vote_done ? S_DONE : S_VOTE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_done = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE:  o_op = i_start ? OP_ACCEPT : OP_IDLE;
            S_RD_A:  o_op = OP_RD_A;
            S_RD_B:  o_op = OP_RD_B;
            S_RD_C:  o_op = OP_RD_C;
            S_DIFF:  o_op = OP_DIFF;
            S_PROD:  o_op = OP_PROD;
            S_SUM:   o_op = OP_SUM;
            S_CHK:   o_op = OP_CHK;
            S_NUM:   o_op = OP_NUM;
            S_NUMS:  o_op = OP_NUMS;
            S_DIVR:  o_op = OP_DIVR;
            S_DIVC:  o_op = OP_DIVC;
            S_CEN:   o_op = OP_CEN;
            S_SQ:    o_op = OP_SQ;
            S_R2:    o_op = OP_R2;
            S_SQRT:  o_op = OP_SQRT;
            S_RAD:   o_op = OP_RAD;
            S_RCHK:  o_op = OP_RCHK;
            S_BAND:  o_op = OP_BAND;
            S_VOTE:  o_op = OP_VOTE;
            S_WDIVR, S_WDIVC, S_WSQRT: o_op = OP_WAIT;
            default: o_op = OP_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/tpcv_dp.sv
// Datapath of the circle vote scorer: point store, configuration registers,
// circle arithmetic, square root and vote pipeline. Depends on tpcv_pkg,
// tpcv_ram and tpcv_div.
`default_nettype none

module tpcv_dp
    import tpcv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_op                   i_op,
    input  wire logic                  i_req_type,
    input  wire logic                  i_start_new_set,
    input  wire logic [COORD_BITS-1:0] i_point_row,
    input  wire logic [COORD_BITS-1:0] i_point_col,
    input  wire logic [IDX_W-1:0]      i_index_a,
    input  wire logic [IDX_W-1:0]      i_index_b,
    input  wire logic [IDX_W-1:0]      i_index_c,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output t_stat                      o_stat,
    output logic signed [OUT_W-1:0]    o_center_row,
    output logic signed [OUT_W-1:0]    o_center_col,
    output logic [OUT_W-1:0]           o_radius,
    output logic [CNT_W-1:0]           o_votes,
    output logic [1:0]                 o_status
);

    localparam int SQC_W = $clog2(ROOT_W + 1);

    // Configuration and control state.
    logic [MINR_W-1:0]   r_min_radius;
    logic [BANDH_W-1:0]  r_band_hw;
    logic [MINDET_W-1:0] r_min_det;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_k;
    logic                r_v1;
    logic                r_v2;
    logic                r_sq_busy;
    logic [SQC_W-1:0]    r_sq_cnt;

    // Payload registers.
    logic [IDX_W-1:0]      r_ia, r_ib, r_ic;
    logic [COORD_BITS-1:0] r_ar, r_ac, r_br, r_bc;
    logic signed [DIFF_W-1:0] r_bx, r_by, r_cx, r_cy;
    logic signed [PROD_W-1:0] r_p1, r_p2, r_s1, r_s2, r_s3, r_s4;
    logic signed [DET_W-1:0]  r_det;
    logic signed [SQ_W-1:0]   r_b2, r_c2;
    logic signed [MP_W-1:0]   r_m1, r_m2, r_m3, r_m4;
    logic signed [NUM_W-1:0]  r_numr, r_numc;
    logic signed [OFF_W-1:0]  r_offr, r_offc;
    logic signed [CEN_W-1:0]  r_cr, r_cc;
    logic signed [OSQ_W-1:0]  r_sqr, r_sqc;
    logic [R2_W-1:0]          r_src;
    logic [ROOT_W-1:0]        r_root;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_rs;
    logic [HI_W-1:0]          r_hi, r_lo;
    logic                     r_use_lo;
    logic signed [DSQ_W-1:0]  r_dr2, r_dc2;
    logic signed [OUT_W-1:0]  r_out_cr, r_out_cc;
    logic [OUT_W-1:0]         r_out_rad;
    logic [CNT_W-1:0]         r_votes;
    t_status                  r_status;

    // Combinational signals.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    logic [PT_W-1:0]        ram_rdata;
    logic [COORD_BITS-1:0]  rd_row, rd_col;
    logic                   store_full;
    logic                   accept_eval;
    logic                   div_start;
    logic                   div_busy;
    logic signed [NUM_W-1:0] div_num;
    logic signed [OFF_W-1:0] div_quot;
    logic [DET_W-1:0]       adet;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   sq_ge;
    logic [BAND_W-1:0]      ap, am;
    logic                   vote_issue;
    logic signed [DR_W-1:0] dr, dc;
    logic [D2_W-1:0]        d2;
    logic                   in_band;

    assign rd_row = ram_rdata[PT_W-1:COORD_BITS];
    assign rd_col = ram_rdata[COORD_BITS-1:0];

    always_comb begin
        store_full  = (r_count == CNT_W'(MAX_POINTS));
        accept_eval = (i_op == OP_ACCEPT) && i_req_type;
        ram_we      = (i_op == OP_ACCEPT) && !i_req_type && (i_start_new_set || !store_full);
        ram_waddr   = i_start_new_set ? '0 : r_count[IDX_W-1:0];
        unique case (i_op)
            OP_RD_A: ram_raddr = r_ia;
            OP_RD_B: ram_raddr = r_ib;
            OP_RD_C: ram_raddr = r_ic;
            OP_VOTE: ram_raddr = r_k[IDX_W-1:0];
            default: ram_raddr = r_ia;
        endcase

        div_start = (i_op == OP_DIVR) || (i_op == OP_DIVC);
        div_num   = (i_op == OP_DIVC) ? r_numc : r_numr;

        adet = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);

        rem_sh = {r_rem[REM_W-3:0], r_src[R2_W-1:R2_W-2]};
        trial  = REM_W'({r_root, 2'b01});
        sq_ge  = rem_sh >= trial;

        ap = BAND_W'(r_rs) + BAND_W'(r_band_hw);
        am = BAND_W'(r_rs) - BAND_W'(r_band_hw);

        vote_issue = (i_op == OP_VOTE) && (r_k != r_count);
        dr = $signed(DR_W'({rd_row, {FRAC_BITS{1'b0}}})) - DR_W'(r_cr);
        dc = $signed(DR_W'({rd_col, {FRAC_BITS{1'b0}}})) - DR_W'(r_cc);
        d2 = D2_W'(r_dr2) + D2_W'(r_dc2);
        in_band = (!r_use_lo || (d2 > D2_W'(r_lo))) && (d2 < D2_W'(r_hi));

        o_stat.bad_index = (CNT_W'(i_index_a) >= r_count) || (CNT_W'(i_index_b) >= r_count)
                        || (CNT_W'(i_index_c) >= r_count);
        o_stat.collinear = (r_det == '0) || (adet < DET_W'(r_min_det));
        o_stat.small_rad = r_rs < ROOT_W'({r_min_radius, {FRAC_BITS{1'b0}}});
        o_stat.div_busy  = div_busy;
        o_stat.sqrt_busy = r_sq_busy;
        o_stat.vote_done = (r_k == r_count) && !r_v1 && !r_v2;

        o_center_row = r_out_cr;
        o_center_col = r_out_cc;
        o_radius     = r_out_rad;
        o_votes      = r_votes;
        o_status     = r_status;
    end

    tpcv_ram #(
        .WIDTH(PT_W),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata({i_point_row, i_point_col}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    tpcv_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_det),
        .o_busy (div_busy),
        .o_quot (div_quot)
    );

    // Control state: configuration, fill count, square-root and vote sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_radius <= MINR_W'(20);
            r_band_hw    <= BANDH_W'(8);
            r_min_det    <= MINDET_W'(1);
            r_count      <= '0;
            r_k          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_sq_busy    <= 1'b0;
            r_sq_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MIN_RADIUS: r_min_radius <= i_cfg_data[MINR_W-1:0];
                    CFG_BAND_HALF:  r_band_hw    <= i_cfg_data[BANDH_W-1:0];
                    CFG_MIN_DET:    r_min_det    <= i_cfg_data[MINDET_W-1:0];
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_count <= i_start_new_set ? CNT_W'(1) : r_count + 1'b1;
            end
            if (i_op == OP_SQRT) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= SQC_W'(ROOT_W);
            end else if (r_sq_busy) begin
                r_sq_cnt <= r_sq_cnt - 1'b1;
                if (r_sq_cnt == SQC_W'(1)) begin
                    r_sq_busy <= 1'b0;
                end
            end
            if (i_op == OP_BAND) begin
                r_k <= '0;
            end else if (vote_issue) begin
                r_k <= r_k + 1'b1;
            end
            r_v1 <= vote_issue;
            r_v2 <= r_v1;
        end
    end

    // Payload: one step of the evaluation per command.
    always_ff @(posedge i_clk) begin
        if (accept_eval) begin
            r_ia      <= i_index_a;
            r_ib      <= i_index_b;
            r_ic      <= i_index_c;
            r_status  <= o_stat.bad_index ? ST_BAD_INDEX : ST_OK;
            r_out_cr  <= '0;
            r_out_cc  <= '0;
            r_out_rad <= '0;
            r_votes   <= '0;
        end
        case (i_op)
            OP_RD_B: begin
                r_ar <= rd_row;
                r_ac <= rd_col;
            end
            OP_RD_C: begin
                r_br <= rd_row;
                r_bc <= rd_col;
            end
            OP_DIFF: begin
                r_bx <= $signed({1'b0, r_br}) - $signed({1'b0, r_ar});
                r_by <= $signed({1'b0, r_bc}) - $signed({1'b0, r_ac});
                r_cx <= $signed({1'b0, rd_row}) - $signed({1'b0, r_ar});
                r_cy <= $signed({1'b0, rd_col}) - $signed({1'b0, r_ac});
            end
            OP_PROD: begin
                r_p1 <= r_bx * r_cy;
                r_p2 <= r_cx * r_by;
                r_s1 <= r_bx * r_bx;
                r_s2 <= r_by * r_by;
                r_s3 <= r_cx * r_cx;
                r_s4 <= r_cy * r_cy;
            end
            OP_SUM: begin
                r_det <= DET_W'(r_p1) - DET_W'(r_p2);
                r_b2  <= SQ_W'(r_s1) + SQ_W'(r_s2);
                r_c2  <= SQ_W'(r_s3) + SQ_W'(r_s4);
            end
            OP_CHK: begin
                if (o_stat.collinear) begin
                    r_status <= ST_COLLINEAR;
                end
            end
            OP_NUM: begin
                r_m1 <= MP_W'(r_cy) * MP_W'(r_b2);
                r_m2 <= MP_W'(r_by) * MP_W'(r_c2);
                r_m3 <= MP_W'(r_bx) * MP_W'(r_c2);
                r_m4 <= MP_W'(r_cx) * MP_W'(r_b2);
            end
            OP_NUMS: begin
                r_numr <= (NUM_W'(r_m1) - NUM_W'(r_m2)) <<< 3;
                r_numc <= (NUM_W'(r_m3) - NUM_W'(r_m4)) <<< 3;
            end
            OP_DIVC: begin
                r_offr <= div_quot;
            end
            OP_CEN: begin
                r_offc <= div_quot;
                r_cr   <= $signed(CEN_W'({r_ar, {FRAC_BITS{1'b0}}})) + CEN_W'(r_offr);
            end
            OP_SQ: begin
                r_cc  <= $signed(CEN_W'({r_ac, {FRAC_BITS{1'b0}}})) + CEN_W'(r_offc);
                r_sqr <= r_offr * r_offr;
                r_sqc <= r_offc * r_offc;
            end
            OP_R2: begin
                r_src    <= R2_W'(r_sqr) + R2_W'(r_sqc);
                r_out_cr <= sat_center(r_cr);
                r_out_cc <= sat_center(r_cc);
            end
            OP_SQRT: begin
                r_root <= '0;
                r_rem  <= '0;
            end
            OP_RAD: begin
                r_rs <= r_root + ROOT_W'(r_rem > REM_W'(r_root));
            end
            OP_RCHK: begin
                r_out_rad <= (r_rs > ROOT_W'({OUT_W{1'b1}})) ? '1 : OUT_W'(r_rs);
                if (o_stat.small_rad) begin
                    r_status <= ST_SMALL;
                end
            end
            OP_BAND: begin
                r_hi     <= ap * ap;
                r_lo     <= am * am;
                r_use_lo <= r_rs >= ROOT_W'(r_band_hw);
            end
            default: ;
        endcase

        // Digit-by-digit square root, two radicand bits per cycle.
        if (r_sq_busy) begin
            r_src  <= {r_src[R2_W-3:0], 2'b00};
            r_rem  <= sq_ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
        end

        // Vote pipeline: read, square, compare and count.
        if (r_v1) begin
            r_dr2 <= dr * dr;
            r_dc2 <= dc * dc;
        end
        if (r_v2 && in_band) begin
            r_votes <= r_votes + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: src/three_point_circle_vote_scorer.sv
// Top level of the three-point circle vote scorer: ties the controller to
// the datapath. Depends on tpcv_pkg, tpcv_ctrl and tpcv_dp.
//
// Usage: an item is presented on the i_ fields and accepted at a rising edge
// where i_start is high and o_busy is low. A load item (req_type 0) writes
// one edge point into the point store in its accept cycle and produces no
// result; o_busy stays low, so loads may follow every cycle. A start mark
// empties the store before the point is added; a load into a full store is
// dropped. An evaluate item (req_type 1) raises o_busy until its result is
// shown for exactly one cycle with o_done high; the receiver cannot stall.
// An evaluation waits on the bit-serial divider, once for each of the two
// center coordinates, and on the square-root unit; the vote pass reads one
// stored point per cycle from the single read port of the store memory. A
// bad index goes from idle straight to done; a collinear triple ends at the
// determinant check. Reset clears the fill count, restores the configuration
// defaults and returns the controller to idle; the store contents are not
// cleared. Configuration is written through i_cfg_we; the user must write
// it only while the block is idle, which the block itself does not enforce.

`default_nettype none

module three_point_circle_vote_scorer
    import tpcv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_req_type,
    input  wire logic                  i_start_new_set,
    input  wire logic [COORD_BITS-1:0] i_point_row,
    input  wire logic [COORD_BITS-1:0] i_point_col,
    input  wire logic [IDX_W-1:0]      i_index_a,
    input  wire logic [IDX_W-1:0]      i_index_b,
    input  wire logic [IDX_W-1:0]      i_index_c,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output logic                       o_done,
    output logic signed [OUT_W-1:0]    o_center_row,
    output logic signed [OUT_W-1:0]    o_center_col,
    output logic [OUT_W-1:0]           o_radius,
    output logic [CNT_W-1:0]           o_votes,
    output logic [1:0]                 o_status
);

    // Command and status between the controller and the datapath.
    t_op   op;
    t_stat stat;
    logic  busy;

    // Gate the start so the datapath only sees an accept when idle.
    tpcv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_req_type(i_req_type),
        .i_stat    (stat),
        .o_op      (op),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    tpcv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_req_type     (i_req_type),
        .i_start_new_set(i_start_new_set),
        .i_point_row    (i_point_row),
        .i_point_col    (i_point_col),
        .i_index_a      (i_index_a),
        .i_index_b      (i_index_b),
        .i_index_c      (i_index_c),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_stat         (stat),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_radius       (o_radius),
        .o_votes        (o_votes),
        .o_status       (o_status)
    );

    assign o_busy = busy;

endmodule

`default_nettype wire
